[design/lzpp_pkg.sv]
package lzpp_pkg;

    localparam int TEXT_CAPACITY_DEF = 4096;

    localparam int OP_W    = 2;
    localparam int POS_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = 12;
    localparam int STAT_W  = 2;
    localparam int SRC_W   = 12;
    localparam int LEN_W   = 13;
    localparam int CNT_W   = 13;
    localparam int TLEN_W  = 13;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_PHRASE = 2'd2,
        OP_COUNT  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_ACK      = 2'd0,
        ST_PHRASE   = 2'd1,
        ST_FINISHED = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  text_byte;
        logic [ENTRY_W-1:0] suffix_entry;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [SRC_W-1:0]   phrase_source;
        logic [LEN_W-1:0]   phrase_length;
        logic               last;
        logic [CNT_W-1:0]   counter_value;
    } t_resp;

endpackage

[design/lz77_phrase_parser_top.sv]
// channel   | signals                          | transfer
// ----------+----------------------------------+----------------------------------
// request   | start, busy, i_req               | start high while busy low
// result    | o_done, o_resp                   | o_done high for one cycle
// config    | i_cfg_valid, o_cfg_ready, i_cfg_data | valid and ready both high
//
// one request at a time; each request gives one result. loads answer from
// S_LOAD, counter reads from S_COUNT_RD and pushes from S_PUSH_CMP.
// a push pops stack entries one at a time, each after a stack memory read.
// a phrase request walks each cursor position through S_ADV_RT..S_ADV_WP (link
// memory read-modify-write), then each compared byte through S_MATCH_RD and
// S_MATCH_CMP (text read then compare). after reset, and on a byte load that
// starts a new text, a clearing pass over addresses 0..TEXT_CAPACITY zeroes all
// memories while busy stays high. the receiver cannot stall results.
module lz77_phrase_parser_top
    import lzpp_pkg::*;
#(
    parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_done,
    output t_resp             o_resp,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TLEN_W-1:0] i_cfg_data
);

    localparam int N  = TEXT_CAPACITY;
    localparam int AW = $clog2(N + 1);
    localparam int TW = $clog2(N);
    localparam int PW = $clog2(2 * N + 2);

    typedef enum logic [11:0] {
        S_CLEAR     = 12'b000000000001,
        S_LOAD      = 12'b000000000010,
        S_IDLE      = 12'b000000000100,
        S_PUSH_CMP  = 12'b000000001000,
        S_ADV_RT    = 12'b000000010000,
        S_ADV_RP    = 12'b000000100000,
        S_ADV_GQ    = 12'b000001000000,
        S_ADV_WP    = 12'b000010000000,
        S_MATCH_RD  = 12'b000100000000,
        S_MATCH_CMP = 12'b001000000000,
        S_COUNT_RD  = 12'b010000000000,
        S_SPARE     = 12'b100000000000
    } t_state;

    typedef enum logic [4:0] {
        PH_SINGLE    = 5'b00001,
        PH_SHARED    = 5'b00010,
        PH_PSV_FIRST = 5'b00100,
        PH_PSV       = 5'b01000,
        PH_NSV       = 5'b10000
    } t_phase;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [TLEN_W-1:0]   r_text_length;
    logic [AW-1:0]       r_clr, n_clr;
    logic                r_clr_load, n_clr_load;
    logic [AW-1:0]       r_top, n_top;
    logic [PW-1:0]       r_rank, n_rank;
    logic [PW-1:0]       r_cursor, n_cursor;
    logic [PW-1:0]       r_nps, n_nps;
    logic [PW-1:0]       r_t, n_t;
    logic [PW-1:0]       r_p, n_p;
    logic [PW-1:0]       r_q, n_q;
    logic [PW-1:0]       r_ba, n_ba;
    logic [PW-1:0]       r_bb, n_bb;
    logic [PW-1:0]       r_len, n_len;
    t_req                r_req, n_req;
    logic                r_done, n_done;
    t_resp               r_resp, n_resp;

    logic [PW-1:0]       w_n;
    logic [PW-1:0]       w_sai;
    logic [PW-1:0]       w_xa, w_xb;
    logic                w_eq;
    logic [PW-1:0]       w_nxt;
    logic                w_pos_ok;

    logic                t_we;
    logic [TW-1:0]       t_waddr, ta_raddr, tb_raddr;
    logic [BYTE_W-1:0]   t_wdata, ta_rdata, tb_rdata;
    logic                l_we;
    logic [AW-1:0]       l_waddr, l_raddr, l_rdata, l_wdata;
    logic                s_we;
    logic [AW-1:0]       s_waddr, s_raddr, s_rdata, s_wdata;
    logic                c_we;
    logic [TW-1:0]       c_waddr, c_raddr;
    logic [CNT_W-1:0]    c_wdata, c_rdata;

    lzpp_ram #(.WIDTH(BYTE_W), .DEPTH(N)) u_text_a (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(ta_raddr), .o_rdata(ta_rdata)
    );

    lzpp_ram #(.WIDTH(BYTE_W), .DEPTH(N)) u_text_b (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(tb_raddr), .o_rdata(tb_rdata)
    );

    lzpp_ram #(.WIDTH(AW), .DEPTH(N + 1)) u_links (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    lzpp_ram #(.WIDTH(AW), .DEPTH(N + 1)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    lzpp_ram #(.WIDTH(CNT_W), .DEPTH(N)) u_counts (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    assign w_n = (32'(r_text_length) > N) ? PW'(N) : PW'(r_text_length);
    assign w_sai = PW'(r_req.suffix_entry) + PW'(1);
    assign w_xa = r_ba + r_len;
    assign w_xb = r_bb + r_len;
    assign w_eq = (w_xa != '0) && (w_xa <= w_n) && (w_xb != '0) && (w_xb <= w_n)
                  && (ta_rdata == tb_rdata);
    assign w_nxt = (r_t + ((r_len == '0) ? PW'(1) : r_len) > w_n + PW'(1))
                   ? w_n + PW'(1) : r_t + ((r_len == '0) ? PW'(1) : r_len);
    assign w_pos_ok = 32'(r_req.position) < N;

    assign ta_raddr = TW'(w_xa - PW'(1));
    assign tb_raddr = TW'(w_xb - PW'(1));

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_clr      = r_clr;
        n_clr_load = r_clr_load;
        n_top      = r_top;
        n_rank     = r_rank;
        n_cursor   = r_cursor;
        n_nps      = r_nps;
        n_t        = r_t;
        n_p        = r_p;
        n_q        = r_q;
        n_ba       = r_ba;
        n_bb       = r_bb;
        n_len      = r_len;
        n_req      = r_req;
        n_done     = 1'b0;
        n_resp     = r_resp;

        t_we    = 1'b0;
        t_waddr = TW'(r_req.position);
        t_wdata = r_req.text_byte;
        l_we    = 1'b0;
        l_waddr = AW'(r_t);
        l_wdata = AW'(r_q);
        l_raddr = AW'(r_t);
        s_we    = 1'b0;
        s_waddr = r_top;
        s_wdata = AW'(w_sai);
        s_raddr = r_top;
        c_we    = 1'b0;
        c_waddr = TW'(w_xa - PW'(1));
        c_wdata = (c_rdata == COUNT_MAX) ? c_rdata : c_rdata + CNT_W'(1);
        c_raddr = TW'(w_xa - PW'(1));

        case (r_state)
            S_CLEAR: begin
                l_we    = 1'b1;
                l_waddr = r_clr;
                l_wdata = '0;
                s_we    = 1'b1;
                s_waddr = r_clr;
                s_wdata = '0;
                t_we    = 32'(r_clr) < N;
                t_waddr = TW'(r_clr);
                t_wdata = '0;
                c_we    = 32'(r_clr) < N;
                c_waddr = TW'(r_clr);
                c_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (32'(r_clr) == N) begin
                    n_top    = '0;
                    n_rank   = '0;
                    n_cursor = PW'(1);
                    n_nps    = PW'(1);
                    n_state  = r_clr_load ? S_LOAD : S_IDLE;
                end
            end
            S_LOAD: begin
                t_we    = w_pos_ok;
                n_done  = 1'b1;
                n_resp  = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    case (i_req.op)
                        OP_LOAD: begin
                            if (r_rank != '0 || r_cursor != PW'(1)) begin
                                n_clr      = '0;
                                n_clr_load = 1'b1;
                                n_state    = S_CLEAR;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        OP_PUSH: begin
                            if (r_rank < w_n && PW'(i_req.suffix_entry) < w_n) begin
                                n_state = S_PUSH_CMP;
                            end else begin
                                n_done = 1'b1;
                                n_resp = '0;
                            end
                        end
                        OP_PHRASE: begin
                            if (r_nps > w_n) begin
                                n_done        = 1'b1;
                                n_resp        = '0;
                                n_resp.status = ST_FINISHED;
                            end else begin
                                n_t     = r_cursor;
                                n_state = S_ADV_RT;
                            end
                        end
                        OP_COUNT: begin
                            if (32'(i_req.position) < N) begin
                                c_raddr = TW'(i_req.position);
                                n_state = S_COUNT_RD;
                            end else begin
                                n_done = 1'b1;
                                n_resp = '0;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_resp = '0;
                        end
                    endcase
                end
            end
            S_PUSH_CMP: begin
                if (r_top != '0 && PW'(s_rdata) > w_sai) begin
                    n_top   = r_top - AW'(1);
                    s_raddr = r_top - AW'(1);
                end else begin
                    l_we    = 1'b1;
                    l_waddr = AW'(w_sai);
                    l_wdata = s_rdata;
                    s_we    = 1'b1;
                    s_waddr = (32'(r_top) < N) ? r_top + AW'(1) : r_top;
                    n_top   = s_waddr;
                    n_rank  = r_rank + PW'(1);
                    n_done  = 1'b1;
                    n_resp  = '0;
                    n_state = S_IDLE;
                end
            end
            S_ADV_RT: begin
                l_raddr = AW'(r_t);
                n_state = S_ADV_RP;
            end
            S_ADV_RP: begin
                n_p     = PW'(l_rdata);
                l_raddr = l_rdata;
                n_state = S_ADV_GQ;
            end
            S_ADV_GQ: begin
                n_q     = PW'(l_rdata);
                l_we    = 1'b1;
                l_waddr = AW'(r_t);
                l_wdata = l_rdata;
                n_state = S_ADV_WP;
            end
            S_ADV_WP: begin
                l_we    = 1'b1;
                l_waddr = AW'(r_p);
                l_wdata = AW'(r_t);
                if (r_t == r_nps) begin
                    n_len = '0;
                    if (r_q == '0) begin
                        n_phase = PH_SINGLE;
                        n_ba    = r_p;
                        n_bb    = r_t;
                    end else if (r_p == '0) begin
                        n_phase = PH_SINGLE;
                        n_ba    = r_q;
                        n_bb    = r_t;
                    end else begin
                        n_phase = PH_SHARED;
                        n_ba    = r_p;
                        n_bb    = r_q;
                    end
                    n_state = S_MATCH_RD;
                end else begin
                    n_t     = r_t + PW'(1);
                    n_state = S_ADV_RT;
                end
            end
            S_MATCH_RD: begin
                n_state = S_MATCH_CMP;
            end
            S_MATCH_CMP: begin
                n_state = S_MATCH_RD;
                if (w_eq) begin
                    c_we  = 1'b1;
                    n_len = r_len + PW'(1);
                    if (r_phase == PH_PSV_FIRST) begin
                        n_phase = PH_PSV;
                    end
                end else begin
                    case (r_phase)
                        PH_SHARED: begin
                            n_phase = PH_PSV_FIRST;
                            n_bb    = r_t;
                        end
                        PH_PSV_FIRST: begin
                            n_phase = PH_NSV;
                            n_ba    = r_q;
                        end
                        default: begin
                            n_cursor             = r_t + PW'(1);
                            n_nps                = w_nxt;
                            n_done               = 1'b1;
                            n_resp               = '0;
                            n_resp.status        = ST_PHRASE;
                            n_resp.phrase_source = (r_len == '0) ? SRC_W'(tb_rdata)
                                                                 : SRC_W'(r_ba - PW'(1));
                            n_resp.phrase_length = LEN_W'(r_len);
                            n_resp.last          = w_nxt > w_n;
                            n_state              = S_IDLE;
                        end
                    endcase
                end
            end
            S_COUNT_RD: begin
                n_done               = 1'b1;
                n_resp               = '0;
                n_resp.counter_value = c_rdata;
                n_state              = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_phase       <= PH_SINGLE;
            r_text_length <= TLEN_W'(1);
            r_clr         <= '0;
            r_clr_load    <= 1'b0;
            r_top         <= '0;
            r_rank        <= '0;
            r_cursor      <= PW'(1);
            r_nps         <= PW'(1);
            r_done        <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_clr      <= n_clr;
            r_clr_load <= n_clr_load;
            r_top      <= n_top;
            r_rank     <= n_rank;
            r_cursor   <= n_cursor;
            r_nps      <= n_nps;
            r_done     <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_text_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_p    <= n_p;
        r_q    <= n_q;
        r_ba   <= n_ba;
        r_bb   <= n_bb;
        r_len  <= n_len;
        r_req  <= n_req;
        r_resp <= n_resp;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_resp      = r_resp;

endmodule

[design/lzpp_ram.sv]
module lzpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import lzpp_pkg::*;

    localparam int CAP = 4096;
    localparam int MAX_SET = 48;

    typedef struct {
        bit                is_cfg;
        t_req              req;
        logic [TLEN_W-1:0] cfg;
        int                gap;
    } t_pending;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_req              i_req = '0;
    logic              o_done;
    t_resp             o_resp;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [TLEN_W-1:0] i_cfg_data = '0;

    lz77_phrase_parser_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_resp      (o_resp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // parser state mirror
    logic [7:0] text_mem [CAP];
    int         link_mem [CAP+1];
    int         psv_mem [CAP+1];
    int         ref_count [CAP];
    int         stack_ptr, ranks_in, cursor, phrase_start, text_len;

    t_pending pending_q[$];
    t_resp    expected_q[$];
    int       mismatches = 0;
    bit       burst = 1'b0;
    int       req_total = 0;

    function automatic void clear_text();
        for (int k = 0; k < CAP; k++) begin
            text_mem[k] = '0;
            ref_count[k] = 0;
        end
        for (int k = 0; k <= CAP; k++) begin
            link_mem[k] = 0;
            psv_mem[k] = 0;
        end
        stack_ptr = 0;
        ranks_in = 0;
        cursor = 1;
        phrase_start = 1;
    endfunction

    function automatic bit bytes_equal(int a, int b, int n);
        if (a < 0 || b < 0 || a >= n || b >= n) return 1'b0;
        return text_mem[a] == text_mem[b];
    endfunction

    function automatic void credit(int p, int n);
        if (p >= 0 && p < n && ref_count[p] < 8191) ref_count[p]++;
    endfunction

    function automatic int match_phrase(int i, int psv, int nsv, int n, output int src);
        int len;
        len = 0;
        if (nsv == -1) begin
            while (bytes_equal(psv + len, i + len, n)) begin credit(psv + len, n); len++; end
            src = psv;
        end else if (psv == -1) begin
            while (bytes_equal(nsv + len, i + len, n)) begin credit(nsv + len, n); len++; end
            src = nsv;
        end else begin
            while (bytes_equal(psv + len, nsv + len, n)) begin credit(psv + len, n); len++; end
            if (bytes_equal(i + len, psv + len, n)) begin
                while (bytes_equal(i + len, psv + len, n)) begin
                    credit(psv + len, n);
                    len++;
                end
                src = psv;
            end else begin
                while (bytes_equal(i + len, nsv + len, n)) begin
                    credit(nsv + len, n);
                    len++;
                end
                src = nsv;
            end
        end
        if (len == 0) src = (i >= 0 && i < n) ? int'(text_mem[i]) : 0;
        return len;
    endfunction

    function automatic t_resp parse_request(t_req rq);
        t_resp r;
        int    n, sai, t, p, q, src, len, nxt;
        bit    here;
        r = '0;
        n = (text_len > CAP) ? CAP : text_len;
        src = 0;
        len = 0;
        nxt = 0;
        case (rq.op)
            OP_LOAD: begin
                if (ranks_in != 0 || cursor != 1) clear_text();
                text_mem[rq.position] = rq.text_byte;
            end
            OP_PUSH: begin
                sai = int'(rq.suffix_entry) + 1;
                if (ranks_in < n && int'(rq.suffix_entry) < n) begin
                    while (stack_ptr > 0 && psv_mem[stack_ptr] > sai) stack_ptr--;
                    link_mem[sai] = psv_mem[stack_ptr];
                    if (stack_ptr < CAP) stack_ptr++;
                    psv_mem[stack_ptr] = sai;
                    ranks_in++;
                end
            end
            OP_PHRASE: begin
                if (phrase_start > n) begin
                    r.status = ST_FINISHED;
                end else begin
                    t = cursor;
                    while (1) begin
                        p = link_mem[t];
                        q = link_mem[p];
                        here = (t == phrase_start);
                        if (here) begin
                            len = match_phrase(t - 1, p - 1, q - 1, n, src);
                            nxt = t - 1 + (len > 0 ? len : 1) + 1;
                        end
                        link_mem[t] = q;
                        link_mem[p] = t;
                        t++;
                        if (here) break;
                    end
                    cursor = t;
                    if (nxt > n + 1) nxt = n + 1;
                    phrase_start = nxt;
                    r.status = ST_PHRASE;
                    r.phrase_source = src[SRC_W-1:0];
                    r.phrase_length = len[LEN_W-1:0];
                    r.last = (nxt > n);
                end
            end
            default: r.counter_value = ref_count[rq.position][CNT_W-1:0];
        endcase
        return r;
    endfunction

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // driver
    int       drv_gap = 0;
    int       quiet = 0;
    bit       have_cur = 1'b0;
    t_pending cur;

    always @(posedge i_clk) begin
        bit req_done, cfg_done;
        req_done = start && !busy;
        cfg_done = i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (req_done) expected_q = {expected_q, parse_request(i_req)};
            if (cfg_done) text_len = int'(i_cfg_data);
            if (expected_q.size() != 0 || req_done) quiet = 0;
            else quiet++;
            if (!((start && !req_done) || (i_cfg_valid && !cfg_done))) begin
                if (!have_cur && pending_q.size() != 0) begin
                    cur = pending_q.pop_front();
                    have_cur = 1'b1;
                    drv_gap = cur.gap;
                end
                if (!have_cur) begin
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (cur.is_cfg) begin
                    start <= 1'b0;
                    if (quiet >= 12) begin
                        i_cfg_valid <= 1'b1;
                        i_cfg_data <= cur.cfg;
                        have_cur = 1'b0;
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else if (drv_gap > 0) begin
                    drv_gap--;
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_req <= cur.req;
                    i_cfg_valid <= 1'b0;
                    have_cur = 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", o_resp);
            end else begin
                want = expected_q.pop_front();
                if (o_resp.status != want.status || o_resp.phrase_source != want.phrase_source
                        || o_resp.phrase_length != want.phrase_length
                        || o_resp.last != want.last
                        || o_resp.counter_value != want.counter_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp/act: st %0d/%0d src %0d/%0d len %0d/%0d",
                                  " last %0d/%0d cnt %0d/%0d"},
                            want.status, o_resp.status, want.phrase_source, o_resp.phrase_source,
                            want.phrase_length, o_resp.phrase_length, want.last, o_resp.last,
                            want.counter_value, o_resp.counter_value);
                end
            end
        end
    end

    task automatic add_req(t_op op, int pos, int byte_v, int entry);
        t_pending it;
        it.is_cfg = 1'b0;
        it.req.op = op;
        it.req.position = pos[POS_W-1:0];
        it.req.text_byte = byte_v[BYTE_W-1:0];
        it.req.suffix_entry = entry[ENTRY_W-1:0];
        it.cfg = '0;
        it.gap = burst ? 0 : $urandom_range(0, 8);
        pending_q = {pending_q, it};
        req_total++;
    endtask

    task automatic add_cfg(int value);
        t_pending it;
        it.is_cfg = 1'b1;
        it.req = '0;
        it.cfg = value[TLEN_W-1:0];
        it.gap = 0;
        pending_q = {pending_q, it};
    endtask

    logic [7:0] gen_text [MAX_SET];
    int         gen_sa [MAX_SET];

    function automatic bit suffix_less(int a, int b, int n);
        while (a < n && b < n) begin
            if (gen_text[a] != gen_text[b]) return gen_text[a] < gen_text[b];
            a++;
            b++;
        end
        return a >= n;
    endfunction

    // one well-formed data set: text, suffix array in rank order, phrases, counter reads
    task automatic run_set(int n, int alpha, bit early);
        int k, j, tmp, early_at, phrases;
        add_cfg(n);
        for (k = 0; k < n; k++) begin
            case (alpha)
                0: gen_text[k] = 8'($urandom_range(0, 1));
                1: gen_text[k] = 8'($urandom_range(0, 255));
                default: gen_text[k] = 8'h61 + 8'($urandom_range(0, 2));
            endcase
            gen_sa[k] = k;
        end
        for (k = 0; k < n; k++) add_req(OP_LOAD, k, gen_text[k], $urandom_range(0, 4095));
        for (k = 1; k < n; k++) begin
            j = k;
            while (j > 0 && suffix_less(gen_sa[j], gen_sa[j-1], n)) begin
                tmp = gen_sa[j];
                gen_sa[j] = gen_sa[j-1];
                gen_sa[j-1] = tmp;
                j--;
            end
        end
        early_at = early ? $urandom_range(0, n) : -1;
        for (k = 0; k < n; k++) begin
            if (k == early_at) add_req(OP_PHRASE, $urandom_range(0, 4095), 0, 0);
            add_req(OP_PUSH, $urandom_range(0, 4095), $urandom_range(0, 255), gen_sa[k]);
        end
        if ($urandom_range(0, 3) == 0)
            add_req(OP_PUSH, 0, 0, $urandom_range(0, 4095));
        phrases = ($urandom_range(0, 3) == 0) ? n / 2 : n + 1;
        for (k = 0; k < phrases; k++) add_req(OP_PHRASE, 0, $urandom_range(0, 255), 0);
        for (k = 0; k < 3; k++) add_req(OP_COUNT, $urandom_range(0, n - 1), 0, 0);
    endtask

    initial begin
        int k, n;
        text_len = 1;
        clear_text();

        // extremes and special cases
        add_cfg(0);
        add_req(OP_PHRASE, 0, 0, 0);
        add_req(OP_PUSH, 0, 0, 0);
        add_req(OP_COUNT, 4095, 0, 0);
        add_cfg(8191);
        add_req(OP_LOAD, 4095, 255, 4095);
        add_req(OP_LOAD, 0, 0, 0);
        add_req(OP_PUSH, 4095, 255, 4095);
        add_req(OP_COUNT, 4095, 255, 0);
        add_cfg(4096);
        add_req(OP_LOAD, 2048, 170, 2730);
        add_req(OP_PUSH, 0, 0, 5000 - 4096);
        add_req(OP_COUNT, 0, 0, 0);
        run_set(1, 1, 1'b0);
        run_set(4, 0, 1'b1);

        while (req_total < 1600) begin
            burst = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, MAX_SET) : $urandom_range(1, 24);
            run_set(n, $urandom_range(0, 2), $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                for (k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 2))
                        0: add_req(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 255),
                                   $urandom_range(0, 4095));
                        1: add_req(OP_PUSH, $urandom_range(0, 4095), $urandom_range(0, 255),
                                   $urandom_range(0, 4095));
                        default: add_req(OP_COUNT, $urandom_range(0, 4095), 0, 0);
                    endcase
                end
            end
        end
        add_cfg(1);
        add_req(OP_COUNT, 0, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || have_cur || start || i_cfg_valid
                || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #400ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
